[rtl/core/lsps_pkg.sv]
// Package for the line sensor PID steering core: field widths, register
// indexes, reset values, arithmetic constants and the sequencer state type.
// No dependencies.
package lsps_pkg;

  localparam int SENSOR_BITS_W = 11;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int GAIN_W        = 16;
  localparam int SPEED_W       = 7;
  localparam int PERIOD_W      = 10;
  localparam int PWM_W         = 8;
  localparam int ERR_W         = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_INVERTED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIMUM_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 3'd6;

  localparam logic [SPEED_W-1:0]  MEDIUM_SPEED_RST  = 7'd50;
  localparam logic [SPEED_W-1:0]  MAXIMUM_SPEED_RST = 7'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST        = 10'd350;

  localparam int LOST_LEFT_TH  = 4;
  localparam int LOST_RIGHT_TH = -4;

  // PID output is Q8.8
  localparam int PID_FRAC_BITS = 8;
  localparam int ROUND_BIAS    = 255;

  // duty = floor((s+100)*51/20) - 255 for |s| < 100, via x*167127 >> 16
  localparam int SPEED_SAT   = 100;
  localparam int DUTY_OFFSET = 255;
  localparam int DRIVE_RECIP = 167127;
  localparam int RECIP_SHIFT = 16;
  localparam int DRV_Q_W     = 10;
  localparam int MUL_A_W     = 19;

  typedef enum logic [1:0] {
    SIDE_CENTRE,
    SIDE_LEFT,
    SIDE_RIGHT
  } side_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_ROUND,
    ST_SPEED,
    ST_DRIVE_L,
    ST_DRIVE_R,
    ST_DONE
  } state_t;

endpackage

[rtl/core/line_sensor_pid_steering_core.sv]
// Line sensor PID steering core: sensor scan, mean division, shared PID
// multiplier and H-bridge duty mapping under one sequencer.
// Depends on lsps_pkg.
//
// Usage: one sensor sample is an item on the input channel (in_valid /
// in_stall); one set of four PWM duties plus line_error and line_lost is an
// item on the output channel (out_valid / out_stall). Registers are to be written
// through cfg_we / cfg_index / cfg_data while the core is idle; the core does not enforce this.
// The sequencer scans one sensor per cycle, divides the weight sum by the
// hit count one quotient bit per cycle, then runs three PID products,
// rounding, speed and two duty products, the products through one shared
// multiplier. When no sensor sees the line it goes from the scan to the duty products.
// in_stall is high from acceptance until the result is in the output
// register, so a new item is taken only after the last one is finished.
// The output register holds a result while out_stall is high; the next item
// is accepted and worked on meanwhile, and waits in its last step.
// Reset (rst, synchronous) restores the register defaults, clears the PID
// state and lost side and empties the output register.
module line_sensor_pid_steering_core #(
  parameter int SENSOR_COUNT  = 11,
  parameter int INTEGRAL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lsps_pkg::SENSOR_BITS_W-1:0] sensor_bits,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lsps_pkg::PWM_W-1:0]        left_pwm_a,
  output logic [lsps_pkg::PWM_W-1:0]        left_pwm_b,
  output logic [lsps_pkg::PWM_W-1:0]        right_pwm_a,
  output logic [lsps_pkg::PWM_W-1:0]        right_pwm_b,
  output logic signed [lsps_pkg::ERR_W-1:0] line_error,
  output logic                              line_lost
);
  import lsps_pkg::*;

  localparam int QW  = $clog2(SENSOR_COUNT);
  localparam int EW  = QW + 1;
  localparam int WW  = QW + 1;
  localparam int CW  = $clog2(SENSOR_COUNT + 1);
  localparam int SW  = $clog2(SENSOR_COUNT * SENSOR_COUNT) + 1;
  localparam int DKW = $clog2(QW);
  localparam int DVW = SW + QW;
  localparam int BW  = ((INTEGRAL_BITS > 9) ? INTEGRAL_BITS : 9) + 1;
  localparam int PW  = MUL_A_W + BW;
  localparam int ACW = PW + 2;
  localparam int SPW = ACW + 1;
  localparam int EXW = (EW > ERR_W) ? EW : ERR_W;

  localparam logic signed [INTEGRAL_BITS:0] INT_MAX =
    (INTEGRAL_BITS+1)'((longint'(1) << (INTEGRAL_BITS - 1)) - 1);
  localparam logic signed [INTEGRAL_BITS:0] INT_MIN = -INT_MAX - 1;
  localparam logic signed [SPW-1:0] SPD_HI = SPW'(SPEED_SAT);
  localparam logic signed [SPW-1:0] SPD_LO = -SPD_HI;
  localparam logic [PWM_W-1:0] X_OFFSET  = PWM_W'(SPEED_SAT);
  localparam logic [PWM_W-1:0] DUTY_FULL = {PWM_W{1'b1}};

  // configuration
  logic                line_inverted;
  logic [SPEED_W-1:0]  medium_speed;
  logic [SPEED_W-1:0]  maximum_speed;
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_i;
  logic [GAIN_W-1:0]   gain_d;
  logic [PERIOD_W-1:0] update_period;

  // control and PID state
  state_t                          state;
  state_t                          state_next;
  logic signed [EW-1:0]            prev_error;
  logic signed [INTEGRAL_BITS-1:0] integ;
  logic [PERIOD_W-1:0]             sample_count;
  side_t                           lost_side;

  // datapath
  logic [SENSOR_BITS_W-1:0] shreg;
  logic signed [WW-1:0]     wt;
  logic signed [SW-1:0]     sum;
  logic [CW-1:0]            cnt;
  logic                     neg;
  logic [SW-1:0]            rem;
  logic [QW-1:0]            quo;
  logic [DKW-1:0]           dk;
  logic signed [EW-1:0]     err;
  logic                     lost;
  logic signed [PW-1:0]     prod;
  logic signed [ACW-1:0]    acc;
  logic signed [SPW-1:0]    left_speed;
  logic signed [SPW-1:0]    right_speed;
  logic [PWM_W-1:0]         left_a;
  logic [PWM_W-1:0]         left_b;

  // combinational
  logic                       seen;
  logic signed [SW-1:0]       sum_next;
  logic [CW-1:0]              cnt_next;
  logic                       scan_last;
  logic [DVW-1:0]             dv;
  logic                       take;
  logic [QW-1:0]              quo_next;
  logic [EW-1:0]              err_mag;
  logic signed [EW:0]         diff;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [ACW-1:0]      acc_bias;
  logic signed [SPW-1:0]      med_ext;
  logic signed [SPW-1:0]      max_ext;
  logic [PWM_W-1:0]           x_left;
  logic [PWM_W-1:0]           x_right;
  logic [PERIOD_W:0]          sc_next;
  logic signed [INTEGRAL_BITS:0] integ_sum;
  logic [2*PWM_W-1:0]         left_pair;
  logic [2*PWM_W-1:0]         right_pair;
  logic signed [EXW-1:0]      err_wide;
  logic                       out_free;
  logic                       load_out;

  function automatic logic [2*PWM_W-1:0] duty_pair(
    input logic signed [SPW-1:0] s,
    input logic [DRV_Q_W-1:0]    qv
  );
    logic signed [DRV_Q_W:0] m;
    logic [DRV_Q_W:0]        mneg;
    logic [2*PWM_W-1:0]      res;
    m    = $signed({1'b0, qv}) - (DRV_Q_W+1)'(DUTY_OFFSET);
    mneg = -m;
    if (s >= SPD_HI) begin
      res = {{PWM_W{1'b0}}, DUTY_FULL};
    end else if (s <= SPD_LO) begin
      res = {DUTY_FULL, {PWM_W{1'b0}}};
    end else if (m == '0) begin
      res = {DUTY_FULL, DUTY_FULL};
    end else if (!m[DRV_Q_W]) begin
      res = {{PWM_W{1'b0}}, m[PWM_W-1:0]};
    end else begin
      res = {mneg[PWM_W-1:0], {PWM_W{1'b0}}};
    end
    return res;
  endfunction

  assign seen      = line_inverted ? shreg[0] : ~shreg[0];
  assign sum_next  = sum + (seen ? SW'(wt) : SW'(0));
  assign cnt_next  = cnt + CW'(seen);
  assign scan_last = (wt == WW'(SENSOR_COUNT - 1));

  assign dv       = DVW'(cnt) << dk;
  assign take     = (DVW'(rem) >= dv);
  assign quo_next = {quo[QW-2:0], take};
  assign err_mag  = {1'b0, quo_next};

  assign diff     = (EW+1)'(err) - (EW+1)'(prev_error);
  assign acc_bias = acc + (acc[ACW-1] ? ACW'(ROUND_BIAS) : ACW'(0));
  assign med_ext  = $signed(SPW'(medium_speed));
  assign max_ext  = $signed(SPW'(maximum_speed));
  assign x_left   = left_speed[PWM_W-1:0] + X_OFFSET;
  assign x_right  = right_speed[PWM_W-1:0] + X_OFFSET;

  assign sc_next   = {1'b0, sample_count} + (PERIOD_W+1)'(1);
  assign integ_sum = (INTEGRAL_BITS+1)'(integ) + (INTEGRAL_BITS+1)'(err);

  assign left_pair  = duty_pair(left_speed, prod[RECIP_SHIFT+DRV_Q_W-1:RECIP_SHIFT]);
  assign right_pair = duty_pair(right_speed, prod[RECIP_SHIFT+DRV_Q_W-1:RECIP_SHIFT]);
  assign err_wide   = EXW'(err);

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_next = (cnt_next == '0) ? ST_DRIVE_L : ST_DIV;
      end
      ST_DIV:     if (dk == '0) state_next = ST_MUL_P;
      ST_MUL_P:   state_next = ST_MUL_I;
      ST_MUL_I:   state_next = ST_MUL_D;
      ST_MUL_D:   state_next = ST_ACC;
      ST_ACC:     state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_SPEED;
      ST_SPEED:   state_next = ST_DRIVE_L;
      ST_DRIVE_L: state_next = ST_DRIVE_R;
      ST_DRIVE_R: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and shared multiplier operands
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_MUL_P: begin
        mul_a = $signed(MUL_A_W'(gain_p));
        mul_b = BW'(err);
      end
      ST_MUL_I: begin
        mul_a = $signed(MUL_A_W'(gain_i));
        mul_b = BW'(integ);
      end
      ST_MUL_D: begin
        mul_a = $signed(MUL_A_W'(gain_d));
        mul_b = BW'(diff);
      end
      ST_DRIVE_L: begin
        mul_a = MUL_A_W'(DRIVE_RECIP);
        mul_b = $signed(BW'(x_left));
      end
      ST_DRIVE_R: begin
        mul_a = MUL_A_W'(DRIVE_RECIP);
        mul_b = $signed(BW'(x_right));
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      line_inverted <= 1'b0;
      medium_speed  <= MEDIUM_SPEED_RST;
      maximum_speed <= MAXIMUM_SPEED_RST;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      update_period <= PERIOD_RST;
      prev_error    <= '0;
      integ         <= '0;
      sample_count  <= '0;
      lost_side     <= SIDE_CENTRE;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // right duty product stays put while the result waits
      if (state != ST_DONE) prod <= mul_a * mul_b;

      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_INVERTED: line_inverted <= cfg_data[0];
          CFG_MEDIUM_SPEED:  medium_speed  <= cfg_data[SPEED_W-1:0];
          CFG_MAXIMUM_SPEED: maximum_speed <= cfg_data[SPEED_W-1:0];
          CFG_GAIN_P:        gain_p        <= cfg_data[GAIN_W-1:0];
          CFG_GAIN_I:        gain_i        <= cfg_data[GAIN_W-1:0];
          CFG_GAIN_D:        gain_d        <= cfg_data[GAIN_W-1:0];
          CFG_UPDATE_PERIOD: update_period <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          shreg <= sensor_bits;
          wt    <= WW'(-(SENSOR_COUNT - 1));
          sum   <= '0;
          cnt   <= '0;
        end
        ST_SCAN: begin
          shreg <= shreg >> 1;
          wt    <= wt + WW'(2);
          sum   <= sum_next;
          cnt   <= cnt_next;
          if (scan_last) begin
            neg <= sum_next[SW-1];
            rem <= sum_next[SW-1] ? SW'(-sum_next) : SW'(sum_next);
            quo <= '0;
            dk  <= DKW'(QW - 1);
            if (cnt_next == '0) begin
              lost <= 1'b1;
              err  <= '0;
              case (lost_side)
                SIDE_LEFT: begin
                  left_speed  <= max_ext;
                  right_speed <= -max_ext;
                end
                SIDE_RIGHT: begin
                  left_speed  <= -max_ext;
                  right_speed <= max_ext;
                end
                default: begin
                  left_speed  <= med_ext;
                  right_speed <= med_ext;
                end
              endcase
            end else begin
              lost <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          rem <= take ? SW'(DVW'(rem) - dv) : rem;
          quo <= quo_next;
          dk  <= dk - DKW'(1);
          if (dk == '0) err <= neg ? -$signed(err_mag) : $signed(err_mag);
        end
        ST_MUL_P: acc <= '0;
        ST_MUL_I: acc <= acc + ACW'(prod);
        ST_MUL_D: acc <= acc + ACW'(prod);
        ST_ACC:   acc <= acc + ACW'(prod);
        ST_ROUND: acc <= acc_bias >>> PID_FRAC_BITS;
        ST_SPEED: begin
          left_speed  <= med_ext + SPW'(acc);
          right_speed <= med_ext - SPW'(acc);
          if (sc_next > {1'b0, update_period}) begin
            prev_error   <= err;
            sample_count <= '0;
            if (integ_sum > INT_MAX) integ <= INT_MAX[INTEGRAL_BITS-1:0];
            else if (integ_sum < INT_MIN) integ <= INT_MIN[INTEGRAL_BITS-1:0];
            else integ <= integ_sum[INTEGRAL_BITS-1:0];
          end else begin
            sample_count <= sc_next[PERIOD_W-1:0];
          end
          if (err == '0) integ <= '0;
          if (err > LOST_LEFT_TH) lost_side <= SIDE_LEFT;
          else if (err < LOST_RIGHT_TH) lost_side <= SIDE_RIGHT;
          else lost_side <= SIDE_CENTRE;
        end
        ST_DRIVE_R: begin
          left_a <= left_pair[2*PWM_W-1:PWM_W];
          left_b <= left_pair[PWM_W-1:0];
        end
        default: ;
      endcase

      if (load_out) begin
        out_valid   <= 1'b1;
        left_pwm_a  <= left_a;
        left_pwm_b  <= left_b;
        right_pwm_a <= right_pair[2*PWM_W-1:PWM_W];
        right_pwm_b <= right_pair[PWM_W-1:0];
        line_error  <= err_wide[ERR_W-1:0];
        line_lost   <= lost;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
